>>> rtl/z80alu_pkg.sv
// Package for the Z80 ALU: opcode codes, flag positions, masks, bus widths and flag helpers.
`timescale 1ns / 1ps
`default_nettype none
package z80alu_pkg;

  // Operation codes
  typedef enum logic [4:0] {
    OP_ADD8  = 5'd0,
    OP_ADC8  = 5'd1,
    OP_SUB8  = 5'd2,
    OP_SBC8  = 5'd3,
    OP_INC8  = 5'd4,
    OP_DEC8  = 5'd5,
    OP_DAA   = 5'd6,
    OP_CPL   = 5'd7,
    OP_AND   = 5'd8,
    OP_OR    = 5'd9,
    OP_XOR   = 5'd10,
    OP_BIT   = 5'd11,
    OP_ADD16 = 5'd12,
    OP_ADC16 = 5'd13,
    OP_SBC16 = 5'd14,
    OP_RLCA  = 5'd15,
    OP_RRA   = 5'd16,
    OP_RLC   = 5'd17,
    OP_RRC   = 5'd18,
    OP_RL    = 5'd19,
    OP_RR    = 5'd20,
    OP_SLA   = 5'd21,
    OP_SRA   = 5'd22,
    OP_SLL   = 5'd23,
    OP_SRL   = 5'd24
  } op_t;

  // Flag bit positions
  localparam int FL_C  = 0;
  localparam int FL_N  = 1;
  localparam int FL_PV = 2;
  localparam int FL_F3 = 3;
  localparam int FL_H  = 4;
  localparam int FL_F5 = 5;
  localparam int FL_Z  = 6;
  localparam int FL_S  = 7;

  // Flag masks
  localparam logic [7:0] MASK_UNDOC  = 8'h28;  // F3 and F5
  localparam logic [7:0] KEEP_SZPV   = 8'hC4;  // S, Z, PV
  localparam logic [7:0] KEEP_ADD16  = 8'hEC;  // S, Z, F5, F3, PV
  localparam logic [7:0] DAA_LIMIT   = 8'h99;
  localparam logic [7:0] DAA_CORR_HI = 8'h60;
  localparam logic [7:0] DAA_CORR_LO = 8'h06;
  localparam logic [7:0] BIT7_MASK   = 8'h80;

  // Input and output bus widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 6;
  localparam int OUT_DATA_W = 24;

  // S, Z, even parity in PV, and optionally F3/F5 copied from the value
  function automatic logic [7:0] szp_flags(input logic [7:0] v, input logic undoc);
    logic [7:0] f;
    f        = 8'h00;
    f[FL_PV] = ~^v;
    f[FL_Z]  = (v == 8'h00);
    f[FL_S]  = v[7];
    if (undoc) begin
      f = f | (v & MASK_UNDOC);
    end
    return f;
  endfunction

  // S and Z of an 8-bit value
  function automatic logic [7:0] sz8(input logic [7:0] v);
    logic [7:0] f;
    f       = 8'h00;
    f[FL_Z] = (v == 8'h00);
    f[FL_S] = v[7];
    return f;
  endfunction

endpackage
`default_nettype wire

>>> rtl/z80_alu_with_flags_top.sv
// Top level of the Z80 ALU: input register, flag and result logic, result register.
// A result passes the input register and then the result register before it is valid.
// Throughput: one item per cycle while out_tready holds high; the ALU is a single combinational pass.
// in_tready follows out_tready when both stages hold items, so a full pipe stalls in place.
// Reset (rst_n low, synchronous) clears both valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module z80_alu_with_flags_top
  import z80alu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // operand_a[15:0], operand_b[31:16], flags_in[39:32]
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // opcode[4:0], accumulator_form[5]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // result_value[15:0], flags_out[23:16]
);

  // Input stage registers
  logic        s1_valid_r;
  logic [4:0]  s1_op_r;
  logic [15:0] s1_a_r;
  logic [15:0] s1_b_r;
  logic [7:0]  s1_f_r;
  logic        s1_acc_r;

  // Result stage registers
  logic        out_valid_r;
  logic [15:0] res_r;
  logic [7:0]  flg_r;
  logic [15:0] res_nxt;
  logic [7:0]  flg_nxt;

  logic adv2;
  logic adv1;

  // Pipeline advance control
  assign adv2      = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv2;
  assign adv1      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_op_r  <= in_tuser[4:0];
      s1_acc_r <= in_tuser[5];
      s1_a_r   <= in_tdata[15:0];
      s1_b_r   <= in_tdata[31:16];
      s1_f_r   <= in_tdata[39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      res_r <= res_nxt;
      flg_r <= flg_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {flg_r, res_r};

  // ALU datapath
  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        cin;
  logic        c8;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  dif9;
  logic [4:0]  hdif5;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [16:0] dif17;
  logic [12:0] hdif13;
  logic [7:0]  r8;
  logic [7:0]  corr;
  logic [7:0]  rot8;
  logic        rot_c;

  assign a8  = s1_a_r[7:0];
  assign b8  = s1_b_r[7:0];
  assign cin = s1_f_r[FL_C];
  assign c8  = cin && ((s1_op_r == OP_ADC8) || (s1_op_r == OP_SBC8));

  // Adders and subtractors; the 8-bit ones and the 16-bit adder serve both the plain and carry forms
  assign sum9   = {1'b0, a8} + {1'b0, b8} + {8'h00, c8};
  assign hsum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, c8};
  assign dif9   = {1'b0, a8} - {1'b0, b8} - {8'h00, c8};
  assign hdif5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, c8};
  assign sum17  = {1'b0, s1_a_r} + {1'b0, s1_b_r}
                + {16'h0000, cin && (s1_op_r == OP_ADC16)};
  assign hsum13 = {1'b0, s1_a_r[11:0]} + {1'b0, s1_b_r[11:0]}
                + {12'h000, cin && (s1_op_r == OP_ADC16)};
  assign dif17  = {1'b0, s1_a_r} - {1'b0, s1_b_r} - {16'h0000, cin};
  assign hdif13 = {1'b0, s1_a_r[11:0]} - {1'b0, s1_b_r[11:0]} - {12'h000, cin};

  always_comb begin
    r8      = 8'h00;
    corr    = 8'h00;
    rot8    = 8'h00;
    rot_c   = 1'b0;
    res_nxt = 16'h0000;
    flg_nxt = s1_f_r;
    case (s1_op_r)
      OP_ADD8, OP_ADC8: begin
        r8             = sum9[7:0];
        res_nxt        = {8'h00, r8};
        flg_nxt        = sz8(r8);
        flg_nxt[FL_C]  = sum9[8];
        flg_nxt[FL_PV] = !(a8[7] ^ b8[7]) && (a8[7] ^ r8[7]);
        flg_nxt[FL_H]  = hsum5[4];
      end
      OP_SUB8, OP_SBC8: begin
        r8             = dif9[7:0];
        res_nxt        = {8'h00, r8};
        flg_nxt        = sz8(r8);
        flg_nxt[FL_N]  = 1'b1;
        flg_nxt[FL_C]  = dif9[8];
        flg_nxt[FL_PV] = (a8[7] ^ b8[7]) && (a8[7] ^ r8[7]);
        flg_nxt[FL_H]  = hdif5[4];
        if (s1_op_r == OP_SUB8) begin
          flg_nxt = flg_nxt | (r8 & MASK_UNDOC);
        end
      end
      OP_INC8: begin
        r8             = a8 + 8'h01;
        res_nxt        = {8'h00, r8};
        flg_nxt        = sz8(r8) | (r8 & MASK_UNDOC);
        flg_nxt[FL_C]  = cin;
        flg_nxt[FL_PV] = (r8 == BIT7_MASK);
        flg_nxt[FL_H]  = (a8[3:0] == 4'hF);
      end
      OP_DEC8: begin
        r8             = a8 - 8'h01;
        res_nxt        = {8'h00, r8};
        flg_nxt        = sz8(r8) | (r8 & MASK_UNDOC);
        flg_nxt[FL_C]  = cin;
        flg_nxt[FL_N]  = 1'b1;
        flg_nxt[FL_PV] = (a8 == BIT7_MASK);
        flg_nxt[FL_H]  = (a8[3:0] == 4'h0);
      end
      OP_DAA: begin
        if ((a8 > DAA_LIMIT) || cin) begin
          corr = corr | DAA_CORR_HI;
        end
        if ((a8[3:0] > 4'd9) || s1_f_r[FL_H]) begin
          corr = corr | DAA_CORR_LO;
        end
        r8            = s1_f_r[FL_N] ? (a8 - corr) : (a8 + corr);
        res_nxt       = {8'h00, r8};
        flg_nxt       = szp_flags(r8, 1'b0);
        flg_nxt[FL_N] = s1_f_r[FL_N];
        flg_nxt[FL_C] = (a8 > DAA_LIMIT) || cin;
        flg_nxt[FL_H] = a8[4] ^ r8[4];
      end
      OP_CPL: begin
        res_nxt       = {8'h00, ~a8};
        flg_nxt[FL_N] = 1'b1;
        flg_nxt[FL_H] = 1'b1;
      end
      OP_AND: begin
        r8            = a8 & b8;
        res_nxt       = {8'h00, r8};
        flg_nxt       = szp_flags(r8, 1'b0);
        flg_nxt[FL_H] = 1'b1;
      end
      OP_OR: begin
        r8      = a8 | b8;
        res_nxt = {8'h00, r8};
        flg_nxt = szp_flags(r8, 1'b0);
      end
      OP_XOR: begin
        r8      = a8 ^ b8;
        res_nxt = {8'h00, r8};
        flg_nxt = szp_flags(r8, 1'b0);
      end
      OP_BIT: begin
        // result is zero; Z and PV mirror the masked test
        flg_nxt        = 8'h00;
        flg_nxt[FL_C]  = cin;
        flg_nxt[FL_H]  = 1'b1;
        flg_nxt[FL_Z]  = ((a8 & b8) == 8'h00);
        flg_nxt[FL_PV] = ((a8 & b8) == 8'h00);
        flg_nxt[FL_S]  = (b8 == BIT7_MASK) && a8[7];
      end
      OP_ADD16: begin
        res_nxt       = sum17[15:0];
        flg_nxt       = s1_f_r & KEEP_ADD16;
        flg_nxt[FL_C] = sum17[16];
        flg_nxt[FL_H] = hsum13[12];
      end
      OP_ADC16: begin
        res_nxt        = sum17[15:0];
        flg_nxt        = 8'h00;
        flg_nxt[FL_C]  = sum17[16];
        flg_nxt[FL_PV] = !(s1_a_r[15] ^ s1_b_r[15]) && (s1_a_r[15] ^ sum17[15]);
        flg_nxt[FL_H]  = hsum13[12];
        flg_nxt[FL_Z]  = (sum17[15:0] == 16'h0000);
        flg_nxt[FL_S]  = sum17[15];
      end
      OP_SBC16: begin
        res_nxt        = dif17[15:0];
        flg_nxt        = 8'h00;
        flg_nxt[FL_N]  = 1'b1;
        flg_nxt[FL_C]  = dif17[16];
        flg_nxt[FL_PV] = (s1_a_r[15] ^ s1_b_r[15]) && (s1_a_r[15] ^ dif17[15]);
        flg_nxt[FL_H]  = hdif13[12];
        flg_nxt[FL_Z]  = (dif17[15:0] == 16'h0000);
        flg_nxt[FL_S]  = dif17[15];
      end
      OP_RLCA: begin
        r8            = {a8[6:0], a8[7]};
        res_nxt       = {8'h00, r8};
        flg_nxt       = (s1_f_r & KEEP_SZPV) | (r8 & MASK_UNDOC);
        flg_nxt[FL_C] = a8[7];
      end
      OP_RRA: begin
        r8            = {cin, a8[7:1]};
        res_nxt       = {8'h00, r8};
        flg_nxt       = (s1_f_r & KEEP_SZPV) | (r8 & MASK_UNDOC);
        flg_nxt[FL_C] = a8[0];
      end
      OP_RLC: begin
        r8            = {a8[6:0], a8[7]};
        res_nxt       = {8'h00, r8};
        flg_nxt       = szp_flags(r8, 1'b1);
        flg_nxt[FL_C] = a8[7];
      end
      OP_RRC, OP_RL: begin
        // accumulator form keeps S, Z and PV
        if (s1_op_r == OP_RRC) begin
          rot8  = {a8[0], a8[7:1]};
          rot_c = a8[0];
        end else begin
          rot8  = {a8[6:0], cin};
          rot_c = a8[7];
        end
        res_nxt = {8'h00, rot8};
        if (s1_acc_r) begin
          flg_nxt = (s1_f_r & KEEP_SZPV) | (rot8 & MASK_UNDOC);
        end else begin
          flg_nxt = szp_flags(rot8, 1'b1);
        end
        flg_nxt[FL_C] = rot_c;
      end
      OP_RR: begin
        r8            = {cin, a8[7:1]};
        res_nxt       = {8'h00, r8};
        flg_nxt       = szp_flags(r8, 1'b1);
        flg_nxt[FL_C] = a8[0];
      end
      OP_SLA: begin
        r8            = {a8[6:0], 1'b0};
        res_nxt       = {8'h00, r8};
        flg_nxt       = szp_flags(r8, 1'b1);
        flg_nxt[FL_C] = a8[7];
      end
      OP_SRA: begin
        r8            = {a8[7], a8[7:1]};
        res_nxt       = {8'h00, r8};
        flg_nxt       = szp_flags(r8, 1'b1);
        flg_nxt[FL_C] = a8[0];
      end
      OP_SLL: begin
        r8            = {a8[6:0], 1'b1};
        res_nxt       = {8'h00, r8};
        flg_nxt       = szp_flags(r8, 1'b0);
        flg_nxt[FL_C] = a8[7];
      end
      OP_SRL: begin
        r8            = {1'b0, a8[7:1]};
        res_nxt       = {8'h00, r8};
        flg_nxt       = szp_flags(r8, 1'b1);
        flg_nxt[FL_C] = a8[0];
      end
      default: begin
        // unused opcodes: zero result, flags pass through
        res_nxt = 16'h0000;
        flg_nxt = s1_f_r;
      end
    endcase
  end

  // Checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv2) |=> out_tvalid)
    else $error("input stage item did not reach result register");

  a_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv2 && (s1_op_r == OP_BIT)) |=> (out_tdata[15:0] == 16'h0000))
    else $error("bit test gave nonzero result");

  a_cpl_nh: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv2 && (s1_op_r == OP_CPL))
      |=> (out_tdata[16+FL_N] && out_tdata[16+FL_H]))
    else $error("cpl did not set N and H");

endmodule
`default_nettype wire
